[rtl/rgbhsv_pkg.sv]
// Shared types, constants and divider step functions for the RGB to HSV converter.
package rgbhsv_pkg;

	localparam int unsigned CH_W        = 8;
	localparam int unsigned HUE_W       = 16;
	localparam int unsigned SAT_W       = 16;
	localparam int unsigned HDIV_W      = 11;
	localparam int unsigned HREM_W      = 11;
	localparam int unsigned SDIV_W      = 8;
	localparam int unsigned SREM_W      = 8;
	localparam int unsigned STEPS_PER_S = 2;
	localparam int unsigned DIV_STAGES  = HUE_W / STEPS_PER_S;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 40;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [HREM_W-1:0] hrem_t;
	typedef logic [HDIV_W-1:0] hdiv_t;
	typedef logic [SREM_W-1:0] srem_t;
	typedef logic [SDIV_W-1:0] sdiv_t;

	// One restoring division step for hue; the dividend's shifted-in bit is always zero.
	function automatic logic [HREM_W:0] hue_step(input hrem_t rem, input hdiv_t dv);
		logic [HREM_W:0] t;
		t = {rem, 1'b0};
		if (t >= {1'b0, dv}) begin
			hue_step = {1'b1, HREM_W'(t - {1'b0, dv})};
		end else begin
			hue_step = {1'b0, t[HREM_W-1:0]};
		end
	endfunction

	// One restoring division step for saturation with the next dividend bit shifted in.
	function automatic logic [SREM_W:0] sat_step(input srem_t rem, input sdiv_t dv,
		input logic bit_in);
		logic [SREM_W:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, dv}) begin
			sat_step = {1'b1, SREM_W'(t - {1'b0, dv})};
		end else begin
			sat_step = {1'b0, t[SREM_W-1:0]};
		end
	endfunction

endpackage

[rtl/rgb_to_hsv_converter.sv]
// Pipelined RGB to HSV pixel converter with two shared-structure restoring dividers.
// Each accepted beat passes the input register, stage 0 and the divider stages.
// Throughput is one pixel per cycle; the whole pipeline stalls together on m_axis_tready.
// Two quotients of 16 bits are formed two bits per stage over eight stages.
// Reset clears all valid bits asynchronously; data registers are not reset.
module rgb_to_hsv_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	input  logic [rgbhsv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: hue[15:0], saturation[31:16], value[39:32].
	output logic [rgbhsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// Fields from bit 0: hue_undefined[0].
	output logic [0:0]                           m_axis_tuser
);
	import rgbhsv_pkg::*;

	logic en;

	chan_t      red_in, green_in, blue_in;
	chan_t      hi_c, lo_c;
	logic [1:0] sec_c;

	logic       v_s1;
	chan_t      red_s1, green_s1, blue_s1, hi_s1, d_s1;
	logic [1:0] sec_s1;

	logic [11:0] n_c;
	logic [11:0] two_d, four_d, six_d;
	logic [23:0] sat_x;

	logic  v_s    [DIV_STAGES+1];
	hrem_t hrem_s [DIV_STAGES+1];
	hdiv_t hdiv_s [DIV_STAGES+1];
	logic [HUE_W-1:0] hq_s [DIV_STAGES+1];
	srem_t srem_s [DIV_STAGES+1];
	sdiv_t sdiv_s [DIV_STAGES+1];
	logic [SAT_W-1:0] sq_s [DIV_STAGES+1];
	logic [SAT_W-1:0] slow_s [DIV_STAGES+1];
	chan_t val_s  [DIV_STAGES+1];
	logic  und_s  [DIV_STAGES+1];

	assign en            = !v_s[DIV_STAGES] || m_axis_tready;
	assign s_axis_tready = en;

	assign red_in   = s_axis_tdata[7:0];
	assign green_in = s_axis_tdata[15:8];
	assign blue_in  = s_axis_tdata[23:16];

	always_comb begin
		hi_c = red_in;
		if (green_in > hi_c) hi_c = green_in;
		if (blue_in > hi_c) hi_c = blue_in;
		lo_c = red_in;
		if (green_in < lo_c) lo_c = green_in;
		if (blue_in < lo_c) lo_c = blue_in;
		if (blue_in == hi_c) begin
			sec_c = SEC_BLUE;
		end else if (green_in == hi_c) begin
			sec_c = SEC_GREEN;
		end else begin
			sec_c = SEC_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
			hi_s1    <= hi_c;
			d_s1     <= hi_c - lo_c;
			sec_s1   <= sec_c;
		end
	end

	always_comb begin
		two_d  = {3'b0, d_s1, 1'b0};
		four_d = {2'b0, d_s1, 2'b0};
		six_d  = two_d + four_d;
		sat_x  = {d_s1, 16'b0} - {16'b0, d_s1};
		case (sec_s1)
			SEC_BLUE:  n_c = {4'b0, red_s1} + four_d - {4'b0, green_s1};
			SEC_GREEN: n_c = {4'b0, blue_s1} + two_d - {4'b0, red_s1};
			SEC_RED: begin
				if (green_s1 >= blue_s1) begin
					n_c = {4'b0, green_s1} - {4'b0, blue_s1};
				end else begin
					n_c = {4'b0, green_s1} + six_d - {4'b0, blue_s1};
				end
			end
			default:   n_c = 12'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_s1 == '0) begin
				hrem_s[0] <= '0;
				hdiv_s[0] <= HDIV_W'(1);
				sdiv_s[0] <= SDIV_W'(1);
			end else begin
				hrem_s[0] <= n_c[HREM_W-1:0];
				hdiv_s[0] <= six_d[HDIV_W-1:0];
				sdiv_s[0] <= hi_s1;
			end
			srem_s[0] <= sat_x[23:16];
			slow_s[0] <= sat_x[15:0];
			hq_s[0]   <= '0;
			sq_s[0]   <= '0;
			val_s[0]  <= hi_s1;
			und_s[0]  <= (hi_s1 == '0);
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		hrem_t            h_n;
		srem_t            s_n;
		logic [HUE_W-1:0] hq_n;
		logic [SAT_W-1:0] sq_n;
		logic [SAT_W-1:0] sl_n;

		always_comb begin
			logic [HREM_W:0] hres;
			logic [SREM_W:0] sres;
			h_n  = hrem_s[k];
			s_n  = srem_s[k];
			hq_n = hq_s[k];
			sq_n = sq_s[k];
			sl_n = slow_s[k];
			for (int j = 0; j < STEPS_PER_S; j++) begin
				hres = hue_step(h_n, hdiv_s[k]);
				sres = sat_step(s_n, sdiv_s[k], sl_n[SAT_W-1]);
				h_n  = hres[HREM_W-1:0];
				s_n  = sres[SREM_W-1:0];
				hq_n = {hq_n[HUE_W-2:0], hres[HREM_W]};
				sq_n = {sq_n[SAT_W-2:0], sres[SREM_W]};
				sl_n = {sl_n[SAT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s[k+1] <= h_n;
				hdiv_s[k+1] <= hdiv_s[k];
				hq_s[k+1]   <= hq_n;
				srem_s[k+1] <= s_n;
				sdiv_s[k+1] <= sdiv_s[k];
				sq_s[k+1]   <= sq_n;
				slow_s[k+1] <= sl_n;
				val_s[k+1]  <= val_s[k];
				und_s[k+1]  <= und_s[k];
			end
		end
	end

	assign m_axis_tvalid   = v_s[DIV_STAGES];
	assign m_axis_tdata    = {val_s[DIV_STAGES], sq_s[DIV_STAGES], hq_s[DIV_STAGES]};
	assign m_axis_tuser[0] = und_s[DIV_STAGES];

endmodule

[rtl/rgbhsv_checker.sv]
// Port-level checks for the RGB to HSV converter and their bind to the top level.
module rgbhsv_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [rgbhsv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [rgbhsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [0:0]                           m_axis_tuser
);
	import rgbhsv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Output beat changed while stalled.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input not ready while output register is empty.");

	a_black_undefined: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[39:32] == 8'd0) == m_axis_tuser[0]))
		else $error("Undefined hue flag disagrees with value.");

	a_gray_hue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[31:16] == 16'd0) |-> (m_axis_tdata[15:0] == 16'd0))
		else $error("Nonzero hue with zero saturation.");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[sim/rgb_to_hsv_converter_test.sv]
// Self-checking stream testbench for the RGB to HSV pixel converter.
module rgb_to_hsv_converter_test;

	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsv_pkg::*;

	localparam int RANDOM_PIXELS = 1700;
	localparam int PHASE_LEN     = 170;
	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		chan_t            value;
		logic             hue_undefined;
	} hsv_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  typed;
		hsv_t  known;
	} pixel_case_t;

	localparam hsv_t NO_HSV = '0;

	localparam pixel_case_t PIXEL_CASES [21] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd0,     8'd0,   1'b1}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0, 16'd0,     8'd255, 1'b0}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0, 16'd0,     8'd1,   1'b0}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0, 16'd0,     8'd128, 1'b0}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0, 16'd65535, 8'd255, 1'b0}},
		'{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd65535, 8'd1,   1'b0}},
		'{8'd0,   8'd255, 8'd0,   1'b0, NO_HSV},
		'{8'd0,   8'd0,   8'd255, 1'b0, NO_HSV},
		'{8'd255, 8'd255, 8'd0,   1'b0, NO_HSV},
		'{8'd0,   8'd255, 8'd255, 1'b0, NO_HSV},
		'{8'd255, 8'd0,   8'd255, 1'b0, NO_HSV},
		'{8'd255, 8'd0,   8'd1,   1'b0, NO_HSV},
		'{8'd255, 8'd1,   8'd0,   1'b0, NO_HSV},
		'{8'd0,   8'd1,   8'd0,   1'b0, NO_HSV},
		'{8'd0,   8'd0,   8'd1,   1'b0, NO_HSV},
		'{8'd1,   8'd2,   8'd3,   1'b0, NO_HSV},
		'{8'd254, 8'd255, 8'd253, 1'b0, NO_HSV},
		'{8'd170, 8'd85,  8'd0,   1'b0, NO_HSV},
		'{8'd85,  8'd170, 8'd255, 1'b0, NO_HSV},
		'{8'd170, 8'd85,  8'd170, 1'b0, NO_HSV},
		'{8'd255, 8'd254, 8'd255, 1'b0, NO_HSV}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	hsv_t pending_hsv [$];
	int   mismatches = 0;
	int   cycle_count = 0;
	int   sender_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_requests = 0;

	rgb_to_hsv_converter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic hsv_t convert_pixel(input chan_t red, input chan_t green,
		input chan_t blue);
		int unsigned r, g, b, top, bottom, span, numer;
		hsv_t res;
		r = {24'd0, red};
		g = {24'd0, green};
		b = {24'd0, blue};
		top = r;
		if (g > top) top = g;
		if (b > top) top = b;
		bottom = r;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		span = top - bottom;
		res = '0;
		res.value = chan_t'(top);
		if (top == 0) begin
			res.hue_undefined = 1'b1;
		end else if (span != 0) begin
			res.saturation = SAT_W'((span * 65535) / top);
			if (top == b) begin
				numer = r + 4 * span - g;
			end else if (top == g) begin
				numer = b + 2 * span - r;
			end else if (g >= b) begin
				numer = g - b;
			end else begin
				numer = g + 6 * span - b;
			end
			res.hue = HUE_W'((numer * 65536) / (6 * span));
		end
		return res;
	endfunction

	task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
		input hsv_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {blue, green, red};
		do @(posedge clk); while (!s_axis_tready);
		pending_hsv.push_back(want);
		@(negedge clk);
	endtask

	initial begin : ready_driver
		int holds_served;
		int hold_left;
		logic stall;
		holds_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall = 1'b1;
			end else begin
				stall = $urandom_range(99) < stall_pct;
			end
			m_axis_tready <= !stall;
		end
	end

	always @(posedge clk) begin : result_check
		hsv_t got;
		hsv_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hue           = m_axis_tdata[15:0];
			got.saturation    = m_axis_tdata[31:16];
			got.value         = m_axis_tdata[39:32];
			got.hue_undefined = m_axis_tuser[0];
			if (pending_hsv.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected beat: hue %0d sat %0d value %0d undef %0d",
						got.hue, got.saturation, got.value, got.hue_undefined);
			end else begin
				want = pending_hsv.pop_front();
				if (got.hue !== want.hue || got.saturation !== want.saturation ||
					got.value !== want.value || got.hue_undefined !== want.hue_undefined) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							want.hue, want.saturation, want.value, want.hue_undefined,
							got.hue, got.saturation, got.value, got.hue_undefined);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		chan_t r, g, b, level;
		hsv_t want;
		int kind;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 19;
		stall_pct = 19;
		foreach (PIXEL_CASES[i]) begin
			if (PIXEL_CASES[i].typed) begin
				want = PIXEL_CASES[i].known;
			end else begin
				want = convert_pixel(PIXEL_CASES[i].red, PIXEL_CASES[i].green,
					PIXEL_CASES[i].blue);
			end
			send_pixel(PIXEL_CASES[i].red, PIXEL_CASES[i].green, PIXEL_CASES[i].blue, want);
		end
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			case ((n / PHASE_LEN) % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 80;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 80;
				end
				default: begin
					sender_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			if (n == 20 || n == 700)
				hold_requests++;
			r = chan_t'($urandom);
			g = chan_t'($urandom);
			b = chan_t'($urandom);
			kind = $urandom_range(9);
			case (kind)
				6: begin
					case ($urandom_range(2))
						0: g = r;
						1: b = g;
						default: b = r;
					endcase
				end
				7: begin
					g = r;
					b = r;
				end
				8: begin
					r = chan_t'($urandom_range(3));
					g = chan_t'($urandom_range(3));
					b = chan_t'($urandom_range(3));
				end
				9: begin
					level = $urandom_range(1) ? 8'd255 : 8'd0;
					r = level ^ chan_t'($urandom_range(1));
					level = $urandom_range(1) ? 8'd255 : 8'd0;
					g = level ^ chan_t'($urandom_range(1));
					level = $urandom_range(1) ? 8'd255 : 8'd0;
					b = level ^ chan_t'($urandom_range(1));
				end
				default: ;
			endcase
			send_pixel(r, g, b, convert_pixel(r, g, b));
		end
		s_axis_tvalid <= 1'b0;
		stall_pct = 19;
		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_hsv.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/rgbhsv_pkg.sv
rtl/rgb_to_hsv_converter.sv
rtl/rgbhsv_checker.sv
sim/rgb_to_hsv_converter_test.sv
